// ===== rtl/core/ppg_heart_rate_detector_assert.svh =====
// assertion macros shared by the heart-rate detector rtl
// depends on nothing; included by the top level
`ifndef PPG_HEART_RATE_DETECTOR_ASSERT_SVH
`define PPG_HEART_RATE_DETECTOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PHR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define PHR_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/phr_pkg.sv =====
// shared types, constants and helpers for the heart-rate detector
// depends on nothing
package phr_pkg;

    localparam int unsigned W_BITS      = 40;
    localparam int unsigned C_BITS      = 17;
    localparam int unsigned TS_BITS     = 32;
    localparam int unsigned BPM_BITS    = 16;
    localparam int unsigned DEF_TAPS    = 5;
    localparam int unsigned DEF_FRAC    = 16;
    localparam int unsigned COEF_FRAC   = 16;
    localparam int unsigned DIGIT_BITS  = 4;
    localparam logic [C_BITS-1:0] BW_B  = 17'd16072;
    localparam logic [C_BITS-1:0] BW_A  = 17'd33392;
    localparam logic [TS_BITS-1:0] BPM_NUM = 32'd60000;

    // register indexes on the write port
    localparam logic [2:0] REG_PEAK_THR  = 3'd0;
    localparam logic [2:0] REG_END_THR   = 3'd1;
    localparam logic [2:0] REG_BASELINE  = 3'd2;
    localparam logic [2:0] REG_GAIN      = 3'd3;
    localparam logic [2:0] REG_DC_ALPHA  = 3'd4;

    typedef logic signed [W_BITS-1:0] t_word;

    // sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DC_MUL,
        ST_DC_ADD,
        ST_MEAN_DIV,
        ST_LP_MUL_B,
        ST_LP_MUL_A,
        ST_BLEND_MUL,
        ST_DETECT,
        ST_BPM_DIV,
        ST_OUT
    } t_state;

    // multiplier request from the sequencer
    typedef struct packed {
        logic                   start;
        logic signed [W_BITS:0] a;
        logic [C_BITS-1:0]      c;
    } t_mul_req;

    // saturate a wide value to a signed word
    function automatic t_word sat40(input logic signed [W_BITS+2:0] x);
        logic signed [W_BITS+2:0] mx;
        logic signed [W_BITS+2:0] mn;
        begin
            mx = (W_BITS+3)'(signed'({1'b0, {(W_BITS-1){1'b1}}}));
            mn = -mx - (W_BITS+3)'(1);
            if (x > mx) sat40 = mx[W_BITS-1:0];
            else if (x < mn) sat40 = mn[W_BITS-1:0];
            else sat40 = x[W_BITS-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/phr_serial_mul.sv =====
// digit-serial signed by unsigned coefficient multiplier, round half up by 2^16
// depends on phr_pkg
module phr_serial_mul
    import phr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mul_req               i_req,
    output logic                   o_done,
    output logic signed [W_BITS+1:0] o_prod
);
    localparam int unsigned PW    = W_BITS + 1 + C_BITS + 1;
    localparam int unsigned STEPS = (C_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int unsigned CW    = $clog2(STEPS + 1);

    logic signed [PW-1:0]     r_acc;
    logic signed [W_BITS:0]   r_a;
    logic [STEPS*DIGIT_BITS-1:0] r_c;
    logic [CW-1:0]            r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic signed [PW-1:0]     n_part;
    logic signed [PW-1:0]     w_rnd;

    // one coefficient digit per cycle, most significant first
    always_comb begin
        n_part = (r_acc <<< DIGIT_BITS)
               + PW'(r_a) * signed'({1'b0, r_c[STEPS*DIGIT_BITS-1 -: DIGIT_BITS]});
        w_rnd = (r_acc + (PW'(1) <<< (COEF_FRAC-1))) >>> COEF_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_c   <= (STEPS*DIGIT_BITS)'(i_req.c);
        end else if (r_busy) begin
            r_acc <= n_part;
            r_c   <= r_c << DIGIT_BITS;
        end
    end

    assign o_done = r_done;
    assign o_prod = w_rnd[W_BITS+1:0];
endmodule

// ===== rtl/core/phr_serial_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on phr_pkg
module phr_serial_div
    import phr_pkg::*;
#(
    parameter int unsigned N_BITS = 44,
    parameter int unsigned D_BITS = 32
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N_BITS-1:0] i_num,
    input  logic [D_BITS-1:0] i_den,
    output logic              o_done,
    output logic [N_BITS-1:0] o_quo
);
    localparam int unsigned CW = $clog2(N_BITS + 1);

    logic [N_BITS-1:0] r_q;
    logic [D_BITS:0]   r_rem;
    logic [D_BITS-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [D_BITS:0]   n_trial;
    logic [D_BITS:0]   n_sh;

    // shift in one numerator bit and try the subtract
    always_comb begin
        n_sh    = {r_rem[D_BITS-1:0], r_q[N_BITS-1]};
        n_trial = n_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_BITS);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!n_trial[D_BITS]) begin
                r_rem <= n_trial;
                r_q   <= {r_q[N_BITS-2:0], 1'b1};
            end else begin
                r_rem <= n_sh;
                r_q   <= {r_q[N_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ===== rtl/core/ppg_heart_rate_detector.sv =====
// PPG heart-rate detector: one sample in, one smoothed value, beat flag and bpm out.
// Each item runs through the sequencer until its result is in the output register and
// the next item can be taken. The sequencer steps are four serial multiplies of 5 digit
// steps on a shared 4-bit-digit unit, a serial mean division of 44 steps and, on a beat
// with a nonzero interval, a serial bpm division of 44 steps on a shared
// one-bit-per-cycle divider. One item is in work at a time; a finished result sits in an
// output register so the next item is taken while it waits, and a stalled output holds
// the last step.
// depends on phr_pkg, phr_serial_mul, phr_serial_div and the assertion header
`include "ppg_heart_rate_detector_assert.svh"
module ppg_heart_rate_detector
    import phr_pkg::*;
#(
    parameter int unsigned MEAN_TAPS = DEF_TAPS,
    parameter int unsigned FRAC_BITS = DEF_FRAC
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [W_BITS-1:0]        i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [15:0]              i_ir_sample,
    input  logic [TS_BITS-1:0]       i_timestamp_ms,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [W_BITS-1:0] o_smoothed_value,
    output logic                     o_beat,
    output logic [BPM_BITS-1:0]      o_rate_bpm
);
    localparam int unsigned SUM_BITS = W_BITS + $clog2(MEAN_TAPS) + 1;
    localparam int unsigned DIV_N    = SUM_BITS;
    localparam int unsigned DIV_D    = TS_BITS;

    // configuration
    t_word            r_peak_thr, r_end_thr, r_base;
    logic [C_BITS-1:0] r_gain;
    logic [15:0]      r_alpha;

    // filter and detector state
    t_word r_dc, r_lp, r_hp, r_sm, r_tmp;
    t_word r_acw [MEAN_TAPS];
    t_word r_shw [4];
    logic  r_armed, r_ended, r_rise_seen, r_latched, r_beat;
    logic [TS_BITS-1:0]  r_last_ts, r_ts;
    logic [15:0]         r_ir;
    logic [BPM_BITS-1:0] r_bpm;
    logic                r_neg;
    t_state r_state, n_state;

    // output register
    logic                r_ovalid;
    t_word               r_osm;
    logic                r_obeat;
    logic [BPM_BITS-1:0] r_obpm;

    t_mul_req w_mreq;
    logic     w_mdone;
    logic signed [W_BITS+1:0] w_mprod;
    logic     w_dstart, w_ddone;
    logic [DIV_N-1:0] w_dnum, w_dquo;
    logic [DIV_D-1:0] w_dden;
    logic signed [SUM_BITS-1:0] w_sum;
    logic [SUM_BITS-1:0] w_sum_mag;
    logic [TS_BITS-1:0]  w_intv;
    logic w_rise, w_fall, w_accept;
    logic signed [SUM_BITS-1:0] w_mean;
    t_word w_ac, w_fin_n, w_v1;
    logic w_armed1, w_hit, w_end, w_ended1, w_rs1, w_clr;

    phr_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_mprod)
    );

    phr_serial_div #(.N_BITS(DIV_N), .D_BITS(DIV_D)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_dquo)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // window sum over the taps
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < MEAN_TAPS; i++) w_sum = w_sum + SUM_BITS'(r_acw[i]);
        w_sum_mag = w_sum[SUM_BITS-1] ? SUM_BITS'(-w_sum) : SUM_BITS'(w_sum);
        w_intv = r_ts - r_last_ts;
    end

    // shape tests on the window after the push
    assign w_rise = (r_shw[3] > r_shw[2]) && (r_shw[2] > r_shw[1]) && (r_shw[1] < r_shw[0]);
    assign w_fall = (r_shw[3] < r_shw[2]) && (r_shw[2] < r_shw[1]) && (r_shw[1] > r_shw[0]);

    // detector flags as updated in order: arm, beat, end, re-arm clear
    assign w_armed1 = r_armed || (r_sm > r_peak_thr);
    assign w_hit    = w_fall && w_armed1 && !r_latched;
    assign w_end    = (r_sm < r_end_thr) && w_armed1;
    assign w_ended1 = r_ended || w_end;
    assign w_rs1    = r_rise_seen || (w_rise && !r_armed);
    assign w_clr    = w_rise && w_rs1 && w_ended1;

    // sequencer next state and unit requests
    always_comb begin
        n_state  = r_state;
        w_mreq   = '0;
        w_dstart = 1'b0;
        w_dnum   = '0;
        w_dden   = '0;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_DC_MUL;
            ST_DC_MUL: begin
                w_mreq.start = 1'b1;
                w_mreq.a = (W_BITS+1)'(r_dc);
                w_mreq.c = C_BITS'(r_alpha);
                n_state = ST_DC_ADD;
            end
            ST_DC_ADD: if (w_mdone) n_state = ST_MEAN_DIV;
            ST_MEAN_DIV: begin
                if (r_tmp == '0) begin
                    w_dstart = 1'b1;
                    w_dnum = w_sum_mag;
                    w_dden = DIV_D'(MEAN_TAPS);
                end
                if (w_ddone) n_state = ST_LP_MUL_B;
            end
            ST_LP_MUL_B: if (w_mdone) n_state = ST_LP_MUL_A;
            ST_LP_MUL_A: if (w_mdone) n_state = ST_BLEND_MUL;
            ST_BLEND_MUL: if (w_mdone) n_state = ST_DETECT;
            ST_DETECT: begin
                if (w_hit) begin
                    if (w_intv == '0) n_state = ST_OUT;
                    else begin
                        w_dstart = 1'b1;
                        w_dnum = DIV_N'(BPM_NUM);
                        w_dden = w_intv;
                        n_state = ST_BPM_DIV;
                    end
                end else n_state = ST_OUT;
            end
            ST_BPM_DIV: if (w_ddone) n_state = ST_OUT;
            ST_OUT: if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        // start multiplies on state entry
        if (r_state == ST_MEAN_DIV && w_ddone) begin
            w_mreq.start = 1'b1;
            w_mreq.c = BW_B;
            w_mreq.a = (W_BITS+1)'(w_ac);
        end
        if (r_state == ST_LP_MUL_B && w_mdone) begin
            w_mreq.start = 1'b1;
            w_mreq.a = (W_BITS+1)'(r_lp);
            w_mreq.c = BW_A;
        end
        if (r_state == ST_LP_MUL_A && w_mdone) begin
            w_mreq.start = 1'b1;
            w_mreq.a = (W_BITS+1)'(w_fin_n) - (W_BITS+1)'(r_base);
            w_mreq.c = r_gain;
        end
    end

    // the operand of the B and gain multiplies is settled in the same cycle
    always_comb begin
        w_mean = w_ddone ? (r_neg ? -SUM_BITS'(w_dquo) : SUM_BITS'(w_dquo)) : '0;
        w_ac   = sat40((W_BITS+3)'(w_mean) - (W_BITS+3)'(r_hp));
        w_v1   = sat40((W_BITS+3)'(r_tmp) + (W_BITS+3)'(w_mprod));
        w_fin_n = sat40((W_BITS+3)'(r_lp) + (W_BITS+3)'(w_v1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_thr <= t_word'(65536);
            r_end_thr <= '0;
            r_base <= t_word'(19661);
            r_gain <= C_BITS'(53620);
            r_alpha <= 16'd62259;
            r_dc <= '0; r_lp <= '0;
            for (int i = 0; i < MEAN_TAPS; i++) r_acw[i] <= '0;
            for (int i = 0; i < 4; i++) r_shw[i] <= '0;
            r_armed <= 1'b0; r_ended <= 1'b0; r_rise_seen <= 1'b0; r_latched <= 1'b0;
            r_last_ts <= '0; r_bpm <= '1; r_beat <= 1'b0;
            r_ovalid <= 1'b0; r_tmp <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PEAK_THR: r_peak_thr <= i_cfg_data;
                    REG_END_THR:  r_end_thr <= i_cfg_data;
                    REG_BASELINE: r_base <= i_cfg_data;
                    REG_GAIN:     r_gain <= i_cfg_data[C_BITS-1:0];
                    REG_DC_ALPHA: r_alpha <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // output register handshake
            if (r_state == ST_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_ir <= i_ir_sample;
                    r_ts <= i_timestamp_ms;
                end
                ST_DC_ADD: if (w_mdone) begin
                    r_tmp <= '0;
                    r_dc <= sat40((W_BITS+3)'({r_ir, FRAC_BITS'(0)}) + (W_BITS+3)'(w_mprod));
                    r_hp <= sat40((W_BITS+3)'(sat40((W_BITS+3)'({r_ir, FRAC_BITS'(0)})
                            + (W_BITS+3)'(w_mprod))) - (W_BITS+3)'(r_dc));
                    for (int i = 0; i < MEAN_TAPS-1; i++) r_acw[i] <= r_acw[i+1];
                    r_acw[MEAN_TAPS-1] <= sat40((W_BITS+3)'(sat40((W_BITS+3)'(
                            {r_ir, FRAC_BITS'(0)}) + (W_BITS+3)'(w_mprod)))
                            - (W_BITS+3)'(r_dc));
                end
                ST_MEAN_DIV: begin
                    if (r_tmp == '0) begin
                        r_neg <= w_sum[SUM_BITS-1];
                        r_tmp <= t_word'(1);
                    end
                end
                ST_LP_MUL_B: if (w_mdone) r_tmp <= w_mprod[W_BITS-1:0];
                ST_LP_MUL_A: if (w_mdone) r_lp <= w_v1;
                ST_BLEND_MUL: if (w_mdone) begin
                    r_sm <= sat40((W_BITS+3)'(r_base) + (W_BITS+3)'(w_mprod));
                    for (int i = 0; i < 3; i++) r_shw[i] <= r_shw[i+1];
                    r_shw[3] <= sat40((W_BITS+3)'(r_base) + (W_BITS+3)'(w_mprod));
                end
                ST_DETECT: begin
                    r_beat      <= w_hit;
                    r_armed     <= w_armed1 && !w_end;
                    r_ended     <= w_ended1 && !w_clr;
                    r_rise_seen <= w_rs1 && !w_clr;
                    r_latched   <= (r_latched || w_hit) && !w_clr;
                    if (w_hit) begin
                        r_last_ts <= r_ts;
                        if (w_intv == '0) r_bpm <= '1;
                    end
                end
                ST_BPM_DIV: if (w_ddone) begin
                    if (w_dquo == '0 || w_dquo > DIV_N'(16'hFFFF)) r_bpm <= '1;
                    else r_bpm <= w_dquo[BPM_BITS-1:0];
                end
                ST_OUT: if (!r_ovalid || i_ready) begin
                    r_osm <= r_sm;
                    r_obeat <= r_beat;
                    r_obpm <= r_bpm;
                end
                default: ;
            endcase
        end
    end

    // outputs come straight from the output register
    assign o_valid = r_ovalid;
    assign o_smoothed_value = r_osm;
    assign o_beat = r_obeat;
    assign o_rate_bpm = r_obpm;

    `PHR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == ST_IDLE)
    `PHR_ASSERT_NXT(a_arm_end, i_clk, i_rst_n, (r_state == ST_DETECT) && w_end, !r_armed)
    `PHR_ASSERT_IMP(a_beat_latched, i_clk, i_rst_n, (r_state == ST_OUT) && r_beat, r_last_ts == r_ts)
endmodule

// ===== tb/tb_top.sv =====
// testbench for the ppg heart-rate detector: predicts each result and checks it
// depends on phr_pkg and the ppg_heart_rate_detector rtl
`timescale 1ns / 1ps
module tb_top
    import phr_pkg::*;
();

    localparam int DRAIN_CYCLES = 200;
    // index past the register list, ignored by the block
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_index = '0;
    logic [W_BITS-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [15:0]       i_ir_sample = '0;
    logic [31:0]       i_timestamp_ms = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_word             o_smoothed_value;
    logic              o_beat;
    logic [15:0]       o_rate_bpm;

    ppg_heart_rate_detector dut (.*);

    // one predicted result item
    typedef struct {
        t_word       smoothed;
        logic        beat;
        logic [15:0] bpm;
    } t_rate_result;

    t_rate_result expected_rates[$];

    // predictor state and register copies
    longint      dc_acc;
    longint      ac_win [5];
    longint      lp_prev;
    longint      shape [4];
    bit          armed, ended, rise_seen, latched;
    logic [31:0] last_beat_ms;
    logic [15:0] bpm_now;
    longint      thr_peak, thr_end, baseline, gain, alpha;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int samples_sent = 0;
    int beats_seen = 0;
    int results_seen = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // overall limit
    initial begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("ppg_heart_rate_detector: mismatch");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic longint clamp40(input longint x);
        if (x > 64'sd549755813887) return 64'sd549755813887;
        if (x < -64'sd549755813888) return -64'sd549755813888;
        return x;
    endfunction

    // q1.16 coefficient product, rounded half up
    function automatic longint q16_mul(input longint a, input longint c);
        return (a * c + 64'sd32768) >>> 16;
    endfunction

    task automatic reset_predictor();
        dc_acc = 0; lp_prev = 0;
        foreach (ac_win[i]) ac_win[i] = 0;
        foreach (shape[i]) shape[i] = 0;
        armed = 0; ended = 0; rise_seen = 0; latched = 0;
        last_beat_ms = '0; bpm_now = 16'hFFFF;
        thr_peak = 65536; thr_end = 0; baseline = 19661; gain = 53620; alpha = 62259;
    endtask

    // filter chain and beat logic for one sample
    task automatic predict_rate(input logic [15:0] ir, input logic [31:0] ts);
        longint x, w, hp, sum, ac, v1, fin, sm;
        bit rise, fall, beat;
        logic [31:0] interval, quot;
        t_rate_result r;
        x = longint'(ir) <<< 16;
        beat = 0;
        w = clamp40(x + q16_mul(dc_acc, alpha));
        hp = clamp40(w - dc_acc);
        dc_acc = w;
        for (int i = 0; i < 4; i++) ac_win[i] = ac_win[i + 1];
        ac_win[4] = hp;
        sum = 0;
        foreach (ac_win[i]) sum += ac_win[i];
        ac = clamp40(sum / 5 - hp);
        v1 = clamp40(q16_mul(ac, longint'(BW_B)) + q16_mul(lp_prev, longint'(BW_A)));
        fin = clamp40(lp_prev + v1);
        lp_prev = v1;
        sm = clamp40(baseline + q16_mul(fin - baseline, gain));
        for (int i = 0; i < 3; i++) shape[i] = shape[i + 1];
        shape[3] = sm;
        rise = shape[3] > shape[2] && shape[2] > shape[1] && shape[1] < shape[0];
        fall = shape[3] < shape[2] && shape[2] < shape[1] && shape[1] > shape[0];
        if (rise && !armed) rise_seen = 1;
        if (sm > thr_peak && !armed) armed = 1;
        if (fall && armed && !latched) begin
            interval = ts - last_beat_ms;
            last_beat_ms = ts;
            latched = 1;
            beat = 1;
            quot = (interval != 0) ? 32'd60000 / interval : 32'd0;
            bpm_now = (quot == 0) ? 16'hFFFF : quot[15:0];
        end
        if (sm < thr_end && armed) begin
            ended = 1;
            armed = 0;
        end
        if (rise && rise_seen && ended) begin
            rise_seen = 0; ended = 0; latched = 0;
        end
        r.smoothed = sm[W_BITS-1:0];
        r.beat = beat;
        r.bpm = bpm_now;
        expected_rates.push_back(r);
    endtask

    // send one sample item and predict its result on acceptance
    task automatic send_sample(input logic [15:0] ir, input logic [31:0] ts);
        i_valid <= 1'b1;
        i_ir_sample <= ir;
        i_timestamp_ms <= ts;
        do @(posedge i_clk); while (!o_ready);
        predict_rate(ir, ts);
        samples_sent++;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [2:0] idx, input logic [W_BITS-1:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PEAK_THR: thr_peak = longint'($signed(data));
            REG_END_THR:  thr_end = longint'($signed(data));
            REG_BASELINE: baseline = longint'($signed(data));
            REG_GAIN:     gain = longint'(data[16:0]);
            REG_DC_ALPHA: alpha = longint'(data[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(input longint pk, input longint en, input longint bl,
                              input longint gn, input longint al);
        write_reg(REG_PEAK_THR, pk[W_BITS-1:0]);
        write_reg(REG_END_THR, en[W_BITS-1:0]);
        write_reg(REG_BASELINE, bl[W_BITS-1:0]);
        write_reg(REG_GAIN, gn[W_BITS-1:0]);
        write_reg(REG_DC_ALPHA, al[W_BITS-1:0]);
    endtask

    // a triangle pulse of the given period and height
    task automatic send_pulse(input int period, input int height, input int floor_lvl,
                              inout logic [31:0] ts, input int max_step);
        int k, half, lvl;
        half = period / 2;
        for (k = 0; k < period; k++) begin
            lvl = (k <= half) ? floor_lvl + height * k / half
                              : floor_lvl + height * (period - k) / (period - half);
            if (lvl > 65535) lvl = 65535;
            ts += $urandom_range(0, max_step);
            send_sample(lvl[15:0], ts);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_rates.size() == 0) begin
                $display("%0t: unexpected result item smoothed %0d", $time, o_smoothed_value);
                errors++;
            end else begin
                t_rate_result e;
                e = expected_rates.pop_front();
                if (o_smoothed_value !== e.smoothed) begin
                    $display("%0t: smoothed expected %0d actual %0d",
                             $time, e.smoothed, o_smoothed_value);
                    errors++;
                end
                if (o_beat !== e.beat) begin
                    $display("%0t: beat expected %0d actual %0d", $time, e.beat, o_beat);
                    errors++;
                end
                if (o_rate_bpm !== e.bpm) begin
                    $display("%0t: bpm expected %0d actual %0d", $time, e.bpm, o_rate_bpm);
                    errors++;
                end
                if (e.beat) beats_seen++;
            end
        end
    end

    // extremes of the sample, zero interval, first beat and long intervals
    task automatic test_directed();
        logic [31:0] ts;
        send_sample(16'h0000, 32'h0000_0000);
        send_sample(16'hFFFF, 32'hFFFF_FFFF);
        send_sample(16'h0000, 32'h0000_0000);
        ts = 0;
        send_pulse(8, 30000, 0, ts, 0);
        ts = 32'hFFFF_FF00;
        send_pulse(8, 30000, 0, ts, 90);
        send_sample(16'hFFFF, ts + 32'd70000);
    endtask

    // register writes including extremes, saturation and an ignored index
    task automatic test_config_extremes();
        logic [31:0] ts;
        ts = $urandom;
        write_reg(REG_UNUSED, 40'hFF_FFFF_FFFF);
        set_config(0, 0, 0, 131071, 65535);
        repeat (12) send_sample(16'hFFFF, ts);
        set_config(-64'sd549755813888, 64'sd549755813887, 64'sd549755813887, 0, 0);
        send_pulse(10, 65535, 0, ts, 500);
        set_config(64'sd549755813887, -64'sd549755813888, -64'sd549755813888, 65536, 1);
        send_pulse(10, 65535, 0, ts, 500);
        set_config(65536, 0, 19661, 53620, 62259);
    endtask

    // mostly pulse trains with random shape, some noise
    task automatic test_random(input int n, input int s_pct, input int r_pct,
                               input bit pause_once);
        logic [31:0] ts;
        int start;
        bit paused;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        ts = $urandom;
        start = samples_sent;
        paused = 0;
        while (samples_sent - start < n) begin
            if ($urandom_range(99) < 80)
                send_pulse($urandom_range(6, 30), $urandom_range(500, 65535),
                           $urandom_range(0, 8000), ts, $urandom_range(0, 1) ? 40 : 20000);
            else
                repeat ($urandom_range(1, 6)) send_sample(16'($urandom), $urandom);
            if (pause_once && !paused && samples_sent - start > n / 2) begin
                i_valid <= 1'b0;
                while (expected_rates.size() != 0) @(posedge i_clk);
                paused = 1;
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(200, 31, 51, 1);
        set_config($urandom_range(0, 400000), -longint'($urandom_range(0, 400000)),
                   $urandom_range(0, 40000), $urandom_range(30000, 65536),
                   $urandom_range(50000, 65535));
        test_random(200, 51, 31, 0);
        set_config(65536, 0, 19661, 53620, 62259);
        test_random(200, 0, 0, 0);
        wait_drained();
        $display("sent %0d samples, checked %0d results with %0d beats",
                 samples_sent, results_seen, beats_seen);
        $display("covered sample and register extremes, saturation and three stall patterns");
        if (errors == 0 && expected_rates.size() == 0)
            $display("ppg_heart_rate_detector: match");
        else
            $display("ppg_heart_rate_detector: mismatch");
        $finish;
    end

endmodule
